>>> rtl/rai_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the ray/annulus intersection core.
// Register index codes and the epsilon constant; no dependencies.
package rai_pkg;

    typedef enum logic [2:0] {
        REG_NORMAL_X = 3'd0,
        REG_NORMAL_Y = 3'd1,
        REG_NORMAL_Z = 3'd2,
        REG_CENTER_X = 3'd3,
        REG_CENTER_Y = 3'd4,
        REG_CENTER_Z = 3'd5,
        REG_OUTER_R  = 3'd6,
        REG_INNER_R  = 3'd7
    } reg_idx_t;

    // 0.0001 in the fixed-point format, never below one LSB
    function automatic int eps_of(input int frac);
        int e;
        begin
            e = ((1 << frac) + 5000) / 10000;
            return (e > 0) ? e : 1;
        end
    endfunction

endpackage

>>> rtl/rai_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage.
// Carries an opaque sideband vector alongside; uses no package items.
module rai_div #(
    parameter int DIV_W  = 50,
    parameter int Q_W    = 31,
    parameter int SIDE_W = 194
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DIV_W-1:0]  in_rem,
    input  logic [DIV_W-1:0]  in_divisor,
    input  logic [Q_W-1:0]    in_low,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [Q_W-1:0]    out_quot,
    output logic [SIDE_W-1:0] out_side
);

    logic [DIV_W-1:0]  rem_reg  [Q_W];
    logic [DIV_W-1:0]  dvs_reg  [Q_W];
    logic [Q_W-1:0]    low_reg  [Q_W];
    logic [Q_W-1:0]    quot_reg [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];
    logic [Q_W-1:0]    valid_reg;
    logic [Q_W-1:0]    en;

    logic [DIV_W-1:0]  rem_in  [Q_W];
    logic [DIV_W-1:0]  dvs_in  [Q_W];
    logic [Q_W-1:0]    low_in  [Q_W];
    logic [Q_W-1:0]    quot_in [Q_W];
    logic [SIDE_W-1:0] side_in [Q_W];
    logic [Q_W-1:0]    valid_in;

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [DIV_W:0]   trial;
        logic             ge;
        logic [DIV_W-1:0] rem_next;
        logic [Q_W-1:0]   quot_next;

        if (k == 0) begin : g_first
            assign rem_in[k]   = in_rem;
            assign dvs_in[k]   = in_divisor;
            assign low_in[k]   = in_low;
            assign quot_in[k]  = '0;
            assign side_in[k]  = in_side;
            assign valid_in[k] = in_valid;
        end else begin : g_rest
            assign rem_in[k]   = rem_reg[k-1];
            assign dvs_in[k]   = dvs_reg[k-1];
            assign low_in[k]   = low_reg[k-1];
            assign quot_in[k]  = quot_reg[k-1];
            assign side_in[k]  = side_reg[k-1];
            assign valid_in[k] = valid_reg[k-1];
        end

        if (k == Q_W - 1) begin : g_last_en
            assign en[k] = !valid_reg[k] || out_ready;
        end else begin : g_mid_en
            assign en[k] = !valid_reg[k] || en[k+1];
        end

        always_comb begin
            trial     = {rem_in[k], low_in[k][Q_W-1]};
            ge        = (trial >= {1'b0, dvs_in[k]});
            rem_next  = ge ? DIV_W'(trial - {1'b0, dvs_in[k]}) : DIV_W'(trial);
            quot_next = {quot_in[k][Q_W-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en[k]) begin
                valid_reg[k] <= valid_in[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                rem_reg[k]  <= rem_next;
                dvs_reg[k]  <= dvs_in[k];
                low_reg[k]  <= low_in[k] << 1;
                quot_reg[k] <= quot_next;
                side_reg[k] <= side_in[k];
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[Q_W-1];
    assign out_quot  = quot_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

>>> rtl/ray_annulus_intersect_core.sv
`timescale 1ns / 1ps
// Ray versus flat annulus intersection, fully pipelined.
// Depends on rai_pkg and rai_div.
//
// One ray enters per cycle while s_tready is high; each ray yields one result
// transaction, with t resolved one bit per stage by the pipelined divider.
// Stages stall individually, so bubbles are squeezed out and input is taken
// while a result waits. Plane offset and squared radii are derived from the
// registers, the offset through nc_prod_reg and nc_sum_reg, the radii through
// ro2_reg and ri2_reg. Misses report hit = 0 with all other fields zero.
module ray_annulus_intersect_core #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  logic [((6*COORD_BITS+7)/8)*8-1:0]         s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // distance, point_x, point_y, point_z, zero pad
    output logic [((4*COORD_BITS-1+7)/8)*8-1:0]       m_tdata,
    // hit
    output logic [0:0]                                m_tuser,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [2:0]                                cfg_index,
    input  logic [COORD_BITS-1:0]                     cfg_data
);

    localparam int W     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int PW    = 2 * W;
    localparam int TW    = PW - F;
    localparam int SW    = TW + 2;
    localparam int NW    = SW + 1;
    localparam int QW    = W - 1;
    localparam int HW    = W - 1 - F;
    localparam int DQ    = 2 * W + 2;
    localparam int RW    = 2 * W - 2;
    localparam int OUT_W = ((4 * W - 1 + 7) / 8) * 8;
    localparam int PAD_W = OUT_W - (4 * W - 1);
    localparam int SIDE_W = 6 * W + 2;
    localparam int EPS   = rai_pkg::eps_of(F);

    localparam logic signed [SW-1:0] EPS_S  = SW'(EPS);
    localparam logic [QW-1:0]        EPS_T  = QW'(EPS);
    localparam logic [QW-1:0]        T_MAX  = {QW{1'b1}};
    localparam logic signed [W-1:0]  C_MAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  C_MIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0]  ONE_C  = W'(1) << F;
    localparam logic [W-2:0]         ONE_R  = (W-1)'(1) << F;

    // ---------------- configuration ----------------
    logic signed [W-1:0] n_reg [3];
    logic signed [W-1:0] c_reg [3];
    logic [W-2:0]        ro_reg;
    logic [W-2:0]        ri_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg[0] <= '0;
            n_reg[1] <= '0;
            n_reg[2] <= ONE_C;
            c_reg[0] <= '0;
            c_reg[1] <= '0;
            c_reg[2] <= '0;
            ro_reg   <= ONE_R;
            ri_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (rai_pkg::reg_idx_t'(cfg_index))
                rai_pkg::REG_NORMAL_X: n_reg[0] <= cfg_data;
                rai_pkg::REG_NORMAL_Y: n_reg[1] <= cfg_data;
                rai_pkg::REG_NORMAL_Z: n_reg[2] <= cfg_data;
                rai_pkg::REG_CENTER_X: c_reg[0] <= cfg_data;
                rai_pkg::REG_CENTER_Y: c_reg[1] <= cfg_data;
                rai_pkg::REG_CENTER_Z: c_reg[2] <= cfg_data;
                rai_pkg::REG_OUTER_R:  ro_reg   <= cfg_data[W-2:0];
                rai_pkg::REG_INNER_R:  ri_reg   <= cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // derived from registers only: N.C, outer^2, inner^2
    logic signed [PW-1:0] nc_prod_reg [3];
    logic signed [SW-1:0] nc_sum_reg;
    logic [RW-1:0]        ro2_reg;
    logic [RW-1:0]        ri2_reg;

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            nc_prod_reg[i] <= n_reg[i] * c_reg[i];
        end
        nc_sum_reg <= SW'(nc_prod_reg[0] >>> F) + SW'(nc_prod_reg[1] >>> F)
                    + SW'(nc_prod_reg[2] >>> F);
        ro2_reg    <= RW'(ro_reg) * RW'(ro_reg);
        ri2_reg    <= RW'(ri_reg) * RW'(ri_reg);
    end

    // ---------------- stall chain ----------------
    logic s1_en, s2_en, s3_en, t_en, m_en, p_en, q_en, out_en;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic t_valid_reg, m_valid_reg, p_valid_reg, q_valid_reg, o_valid_reg;
    logic div_in_ready, div_out_valid;

    assign out_en = !o_valid_reg || m_tready;
    assign q_en   = !q_valid_reg || out_en;
    assign p_en   = !p_valid_reg || q_en;
    assign m_en   = !m_valid_reg || p_en;
    assign t_en   = !t_valid_reg || m_en;
    assign s3_en  = !s3_valid_reg || div_in_ready;
    assign s2_en  = !s2_valid_reg || s3_en;
    assign s1_en  = !s1_valid_reg || s2_en;
    assign s_tready = s1_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            t_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            p_valid_reg  <= 1'b0;
            q_valid_reg  <= 1'b0;
            o_valid_reg  <= 1'b0;
        end else begin
            if (s1_en)  s1_valid_reg <= s_tvalid;
            if (s2_en)  s2_valid_reg <= s1_valid_reg;
            if (s3_en)  s3_valid_reg <= s2_valid_reg;
            if (t_en)   t_valid_reg  <= div_out_valid;
            if (m_en)   m_valid_reg  <= t_valid_reg;
            if (p_en)   p_valid_reg  <= m_valid_reg;
            if (q_en)   q_valid_reg  <= p_valid_reg;
            if (out_en) o_valid_reg  <= q_valid_reg;
        end
    end

    // ---------------- stage 1: products ----------------
    logic signed [W-1:0]  o1_reg [3];
    logic signed [W-1:0]  d1_reg [3];
    logic signed [PW-1:0] nd_prod_reg [3];
    logic signed [PW-1:0] no_prod_reg [3];

    always_ff @(posedge aclk) begin
        if (s1_en) begin
            for (int i = 0; i < 3; i++) begin
                o1_reg[i]      <= $signed(s_tdata[i*W +: W]);
                d1_reg[i]      <= $signed(s_tdata[(3+i)*W +: W]);
                nd_prod_reg[i] <= n_reg[i] * $signed(s_tdata[(3+i)*W +: W]);
                no_prod_reg[i] <= n_reg[i] * $signed(s_tdata[i*W +: W]);
            end
        end
    end

    // ---------------- stage 2: dot products ----------------
    logic signed [W-1:0]  o2_reg [3];
    logic signed [W-1:0]  d2_reg [3];
    logic signed [SW-1:0] denom_reg;
    logic signed [NW-1:0] num_reg;
    logic signed [SW-1:0] no_sum;

    assign no_sum = SW'(no_prod_reg[0] >>> F) + SW'(no_prod_reg[1] >>> F)
                  + SW'(no_prod_reg[2] >>> F);

    always_ff @(posedge aclk) begin
        if (s2_en) begin
            o2_reg    <= o1_reg;
            d2_reg    <= d1_reg;
            denom_reg <= SW'(nd_prod_reg[0] >>> F) + SW'(nd_prod_reg[1] >>> F)
                       + SW'(nd_prod_reg[2] >>> F);
            num_reg   <= NW'(nc_sum_reg) - NW'(no_sum);
        end
    end

    // ---------------- stage 3: sign, magnitude, divider setup ----------------
    logic [NW-1:0] un;
    logic [SW-1:0] ud;
    logic [NW-1:0] un_hi;
    logic          miss_next;
    logic          sat_next;

    always_comb begin
        un        = num_reg[NW-1] ? NW'(-num_reg) : NW'(num_reg);
        ud        = denom_reg[SW-1] ? SW'(-denom_reg) : SW'(denom_reg);
        un_hi     = un >> HW;
        sat_next  = (un_hi >= NW'(ud));
        miss_next = ((denom_reg > -EPS_S) && (denom_reg < EPS_S))
                 || (num_reg == '0) || (num_reg[NW-1] != denom_reg[SW-1]);
    end

    logic [SW-1:0]     rem3_reg;
    logic [SW-1:0]     ud3_reg;
    logic [QW-1:0]     low3_reg;
    logic [SIDE_W-1:0] side3_reg;

    always_ff @(posedge aclk) begin
        if (s3_en) begin
            rem3_reg  <= SW'(un_hi);
            ud3_reg   <= ud;
            low3_reg  <= {un[HW-1:0], {F{1'b0}}};
            side3_reg <= {miss_next, sat_next, d2_reg[2], d2_reg[1], d2_reg[0],
                          o2_reg[2], o2_reg[1], o2_reg[0]};
        end
    end

    // ---------------- divider ----------------
    logic [QW-1:0]     quot;
    logic [SIDE_W-1:0] side_d;

    rai_div #(
        .DIV_W (SW),
        .Q_W   (QW),
        .SIDE_W(SIDE_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s3_valid_reg),
        .in_ready  (div_in_ready),
        .in_rem    (rem3_reg),
        .in_divisor(ud3_reg),
        .in_low    (low3_reg),
        .in_side   (side3_reg),
        .out_valid (div_out_valid),
        .out_ready (t_en),
        .out_quot  (quot),
        .out_side  (side_d)
    );

    // ---------------- stage T: saturate t ----------------
    logic [QW-1:0] t_next;
    assign t_next = side_d[6*W] ? T_MAX : quot;

    logic [QW-1:0]       t_t_reg;
    logic                miss_t_reg;
    logic signed [W-1:0] o_t_reg [3];
    logic signed [W-1:0] d_t_reg [3];

    always_ff @(posedge aclk) begin
        if (t_en) begin
            t_t_reg    <= t_next;
            miss_t_reg <= side_d[6*W+1] || (t_next < EPS_T);
            for (int i = 0; i < 3; i++) begin
                o_t_reg[i] <= $signed(side_d[i*W +: W]);
                d_t_reg[i] <= $signed(side_d[(3+i)*W +: W]);
            end
        end
    end

    // ---------------- stage M: t * D ----------------
    logic [QW-1:0]        t_m_reg;
    logic                 miss_m_reg;
    logic signed [W-1:0]  o_m_reg [3];
    logic signed [PW-1:0] td_reg [3];

    always_ff @(posedge aclk) begin
        if (m_en) begin
            t_m_reg    <= t_t_reg;
            miss_m_reg <= miss_t_reg;
            o_m_reg    <= o_t_reg;
            for (int i = 0; i < 3; i++) begin
                td_reg[i] <= $signed({1'b0, t_t_reg}) * d_t_reg[i];
            end
        end
    end

    // ---------------- stage P: hit point ----------------
    logic signed [TW:0]  psum [3];
    logic signed [W-1:0] p_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            psum[i] = (TW+1)'(td_reg[i] >>> F) + (TW+1)'(o_m_reg[i]);
            if (psum[i] > (TW+1)'(C_MAX)) begin
                p_next[i] = C_MAX;
            end else if (psum[i] < (TW+1)'(C_MIN)) begin
                p_next[i] = C_MIN;
            end else begin
                p_next[i] = W'(psum[i]);
            end
        end
    end

    logic [QW-1:0]       t_p_reg;
    logic                miss_p_reg;
    logic signed [W-1:0] p_p_reg [3];

    always_ff @(posedge aclk) begin
        if (p_en) begin
            t_p_reg    <= t_m_reg;
            miss_p_reg <= miss_m_reg;
            p_p_reg    <= p_next;
        end
    end

    // ---------------- stage Q: squared offsets ----------------
    logic signed [W:0] diff [3];
    logic [W:0]        dmag [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i] = (W+1)'(p_p_reg[i]) - (W+1)'(c_reg[i]);
            dmag[i] = diff[i][W] ? (W+1)'(-diff[i]) : (W+1)'(diff[i]);
        end
    end

    logic [QW-1:0]       t_q_reg;
    logic                miss_q_reg;
    logic signed [W-1:0] p_q_reg [3];
    logic [DQ-1:0]       sq_reg [3];

    always_ff @(posedge aclk) begin
        if (q_en) begin
            t_q_reg    <= t_p_reg;
            miss_q_reg <= miss_p_reg;
            p_q_reg    <= p_p_reg;
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= DQ'(dmag[i]) * DQ'(dmag[i]);
            end
        end
    end

    // ---------------- output stage: radius test ----------------
    logic [DQ+1:0] dist2;
    logic          hit_next;

    always_comb begin
        dist2    = (DQ+2)'(sq_reg[0]) + (DQ+2)'(sq_reg[1]) + (DQ+2)'(sq_reg[2]);
        hit_next = !miss_q_reg && (dist2 >= (DQ+2)'(ri2_reg))
                && (dist2 <= (DQ+2)'(ro2_reg));
    end

    logic                hit_reg;
    logic [QW-1:0]       dist_reg;
    logic signed [W-1:0] pt_reg [3];

    always_ff @(posedge aclk) begin
        if (out_en) begin
            hit_reg  <= hit_next;
            dist_reg <= hit_next ? t_q_reg : '0;
            for (int i = 0; i < 3; i++) begin
                pt_reg[i] <= hit_next ? p_q_reg[i] : '0;
            end
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, pt_reg[2], pt_reg[1], pt_reg[0], dist_reg};

endmodule

>>> rtl/rai_checker.sv
`timescale 1ns / 1ps
// Port-level checks for ray_annulus_intersect_core, bound to the top level.
// Depends on rai_pkg for the epsilon constant.
module rai_checker #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((4*COORD_BITS-1+7)/8)*8-1:0] m_tdata,
    input logic [0:0]                          m_tuser
);

    localparam logic [COORD_BITS-2:0] EPS_T =
        (COORD_BITS-1)'(rai_pkg::eps_of(FRAC_BITS));

    // a miss carries an all-zero payload
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("miss with nonzero payload");

    // a hit is never closer than epsilon
    a_hit_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[COORD_BITS-2:0] >= EPS_T)
        else $error("hit distance below epsilon");

    // with the output empty, nothing can hold the input back
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind ray_annulus_intersect_core rai_checker #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
) u_rai_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
